// File: rtl/core/cpps_pkg.sv
// ----------------------------------------------------------------------------
// cpps_pkg: shared constants and types for the cubic pixel shift core
// Field widths, term slots and the control tag that rides the pipeline.
// ----------------------------------------------------------------------------
package cpps_pkg;

  // defaults for the top level parameters
  localparam int COEF_SETS_DEF = 2;
  localparam int FRAC_BITS_DEF = 16;

  // polynomial shape: ten terms per axis, two axes per set
  localparam int TERMS     = 10;
  localparam int AXES      = 2;
  localparam int SET_WORDS = AXES * TERMS;

  // fixed field widths
  localparam int COEF_W     = 32;
  localparam int POS_W      = 17;
  localparam int IDX_W      = 6;
  localparam int SHIFT_W    = 32;
  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 64;

  // sets that a coefficient index can reach at all
  localparam int IDX_SETS = ((1 << IDX_W) + SET_WORDS - 1) / SET_WORDS;

  // item kinds
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  // term slots: 1, x, y, x^2, y^2, x^3, y^3, xy, x^2y, xy^2
  localparam int T_ONE = 0;
  localparam int T_X   = 1;
  localparam int T_Y   = 2;
  localparam int T_X2  = 3;
  localparam int T_Y2  = 4;
  localparam int T_X3  = 5;
  localparam int T_Y3  = 6;
  localparam int T_XY  = 7;
  localparam int T_X2Y = 8;
  localparam int T_XY2 = 9;

  // one full coefficient set, slot = axis*TERMS + term
  typedef logic [SET_WORDS-1:0][COEF_W-1:0] coef_set_t;

  // control that travels with each pipeline stage
  typedef struct packed {
    logic vld;
    logic ch_ok;
  } tag_t;

endpackage

// File: rtl/core/cpps_ram.sv
// ----------------------------------------------------------------------------
// cpps_ram: generic single write, single read RAM
// One write port, one read port with registered read data and read enable.
// ----------------------------------------------------------------------------
module cpps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/cpps_coef_store.sv
// ----------------------------------------------------------------------------
// cpps_coef_store: coefficient storage
// One RAM per term slot, addressed by set; full set read per item, then
// delayed to line up with the monomials.
// ----------------------------------------------------------------------------
module cpps_coef_store #(
  parameter int COEF_SETS = cpps_pkg::COEF_SETS_DEF
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic                         wr_en,
  input  logic [cpps_pkg::IDX_W-1:0]   wr_idx,
  input  logic [cpps_pkg::COEF_W-1:0]  wr_value,
  input  logic                         rd_ch,
  output cpps_pkg::coef_set_t          coef_o
);

  localparam int AW     = (COEF_SETS > 1) ? $clog2(COEF_SETS) : 1;
  localparam int SLOT_W = $clog2(cpps_pkg::SET_WORDS);

  logic              wr_ok;
  logic [AW-1:0]     wr_addr;
  logic [SLOT_W-1:0] wr_slot;
  cpps_pkg::coef_set_t rd_data;
  cpps_pkg::coef_set_t coef_s2_r;
  cpps_pkg::coef_set_t coef_s3_r;

  // index -> (set, slot): at most a few compares on six bits
  always_comb begin
    wr_ok   = 32'(wr_idx) < 32'(COEF_SETS * cpps_pkg::SET_WORDS);
    wr_addr = '0;
    wr_slot = SLOT_W'(wr_idx);
    for (int k = 1; k < cpps_pkg::IDX_SETS; k++) begin
      if (wr_idx >= cpps_pkg::IDX_W'(k * cpps_pkg::SET_WORDS)) begin
        wr_addr = AW'(k);
        wr_slot = SLOT_W'(wr_idx - cpps_pkg::IDX_W'(k * cpps_pkg::SET_WORDS));
      end
    end
  end

  for (genvar s = 0; s < cpps_pkg::SET_WORDS; s++) begin : g_slot
    cpps_ram #(
      .WIDTH (cpps_pkg::COEF_W),
      .DEPTH (COEF_SETS)
    ) u_ram (
      .clk   (clk),
      .we    (wr_en && wr_ok && (wr_slot == SLOT_W'(s))),
      .waddr (wr_addr),
      .wdata (wr_value),
      .re    (en),
      .raddr (AW'(rd_ch)),
      .rdata (rd_data[s])
    );
  end

  // two stages of delay to meet the monomials
  always_ff @(posedge clk) begin
    if (en) begin
      coef_s2_r <= rd_data;
      coef_s3_r <= coef_s2_r;
    end
  end

  assign coef_o = coef_s3_r;

endmodule

// File: rtl/core/cpps_mono.sv
// ----------------------------------------------------------------------------
// cpps_mono: monomial generator
// Clamps the position, then forms the floored square, cross and cube terms
// over two multiplier stages.
// ----------------------------------------------------------------------------
module cpps_mono #(
  parameter int FRAC_BITS = cpps_pkg::FRAC_BITS_DEF,
  localparam int MW       = FRAC_BITS + 1
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  cpps_pkg::tag_t                    tag_i,
  input  logic [cpps_pkg::POS_W-1:0]        pos_x,
  input  logic [cpps_pkg::POS_W-1:0]        pos_y,
  output cpps_pkg::tag_t                    tag_o,
  output logic [cpps_pkg::TERMS-1:0][MW-1:0] mono_o
);

  localparam int CW = (cpps_pkg::POS_W > MW) ? cpps_pkg::POS_W : MW;
  localparam logic [CW-1:0] ONE_C = CW'(1) << FRAC_BITS;
  localparam logic [MW-1:0] ONE_M = MW'(1) << FRAC_BITS;

  logic [CW-1:0]   px_c;
  logic [CW-1:0]   py_c;
  logic [2*MW-1:0] xx_p, yy_p, xy_p, xxx_p, yyy_p, xxy_p, xyy_p;

  cpps_pkg::tag_t tag_s1_r, tag_s2_r, tag_s3_r;
  logic [MW-1:0]  x_s1_r, y_s1_r;
  logic [MW-1:0]  x_s2_r, y_s2_r, xx_s2_r, yy_s2_r, xy_s2_r;
  logic [cpps_pkg::TERMS-1:0][MW-1:0] mono_r;
  logic [cpps_pkg::TERMS-1:0][MW-1:0] mono_nxt;

  // positions above one saturate to one
  always_comb begin
    px_c = CW'(pos_x);
    py_c = CW'(pos_y);
    if (px_c > ONE_C) begin
      px_c = ONE_C;
    end
    if (py_c > ONE_C) begin
      py_c = ONE_C;
    end
  end

  assign xx_p = (2*MW)'(x_s1_r) * (2*MW)'(x_s1_r);
  assign yy_p = (2*MW)'(y_s1_r) * (2*MW)'(y_s1_r);
  assign xy_p = (2*MW)'(x_s1_r) * (2*MW)'(y_s1_r);

  assign xxx_p = (2*MW)'(xx_s2_r) * (2*MW)'(x_s2_r);
  assign yyy_p = (2*MW)'(yy_s2_r) * (2*MW)'(y_s2_r);
  assign xxy_p = (2*MW)'(xx_s2_r) * (2*MW)'(y_s2_r);
  assign xyy_p = (2*MW)'(x_s2_r) * (2*MW)'(yy_s2_r);

  always_comb begin
    mono_nxt                  = '0;
    mono_nxt[cpps_pkg::T_ONE] = ONE_M;
    mono_nxt[cpps_pkg::T_X]   = x_s2_r;
    mono_nxt[cpps_pkg::T_Y]   = y_s2_r;
    mono_nxt[cpps_pkg::T_X2]  = xx_s2_r;
    mono_nxt[cpps_pkg::T_Y2]  = yy_s2_r;
    mono_nxt[cpps_pkg::T_X3]  = MW'(xxx_p >> FRAC_BITS);
    mono_nxt[cpps_pkg::T_Y3]  = MW'(yyy_p >> FRAC_BITS);
    mono_nxt[cpps_pkg::T_XY]  = xy_s2_r;
    mono_nxt[cpps_pkg::T_X2Y] = MW'(xxy_p >> FRAC_BITS);
    mono_nxt[cpps_pkg::T_XY2] = MW'(xyy_p >> FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_s1_r <= '0;
      tag_s2_r <= '0;
      tag_s3_r <= '0;
    end else if (en) begin
      tag_s1_r <= tag_i;
      tag_s2_r <= tag_s1_r;
      tag_s3_r <= tag_s2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_s1_r  <= MW'(px_c);
      y_s1_r  <= MW'(py_c);
      x_s2_r  <= x_s1_r;
      y_s2_r  <= y_s1_r;
      xx_s2_r <= MW'(xx_p >> FRAC_BITS);
      yy_s2_r <= MW'(yy_p >> FRAC_BITS);
      xy_s2_r <= MW'(xy_p >> FRAC_BITS);
      mono_r  <= mono_nxt;
    end
  end

  assign tag_o  = tag_s3_r;
  assign mono_o = mono_r;

  // clamped positions never exceed one
  a_pos_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    tag_s1_r.vld |-> (x_s1_r <= ONE_M) && (y_s1_r <= ONE_M))
    else $error("clamped position above one");

  // floored cube cannot exceed its base since both are at most one
  a_cube_bound: assert property (@(posedge clk) disable iff (!rst_n)
    tag_s3_r.vld |-> (mono_r[cpps_pkg::T_X3] <= mono_r[cpps_pkg::T_X]) &&
                     (mono_r[cpps_pkg::T_Y3] <= mono_r[cpps_pkg::T_Y]))
    else $error("cube term exceeds linear term");

endmodule

// File: rtl/core/cpps_dot.sv
// ----------------------------------------------------------------------------
// cpps_dot: coefficient dot product and output stage
// Twenty products, a two-level adder tree per axis, then floor and
// saturation into the output register.
// ----------------------------------------------------------------------------
module cpps_dot #(
  parameter int FRAC_BITS = cpps_pkg::FRAC_BITS_DEF,
  localparam int MW       = FRAC_BITS + 1
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  cpps_pkg::tag_t                      tag_i,
  input  logic [cpps_pkg::TERMS-1:0][MW-1:0]  mono_i,
  input  cpps_pkg::coef_set_t                 coef_i,
  output logic                                vld_o,
  output logic [cpps_pkg::SHIFT_W-1:0]        shift_x_o,
  output logic [cpps_pkg::SHIFT_W-1:0]        shift_y_o
);

  localparam int PW   = cpps_pkg::COEF_W + MW + 1;
  localparam int SW   = PW + 4;
  localparam int QW   = SW - FRAC_BITS;
  localparam int HALF = cpps_pkg::TERMS / 2;

  logic signed [PW-1:0] prod_nxt [cpps_pkg::SET_WORDS];
  logic signed [PW-1:0] prod_r   [cpps_pkg::SET_WORDS];
  logic signed [SW-1:0] half_nxt [cpps_pkg::AXES][2];
  logic signed [SW-1:0] half_r   [cpps_pkg::AXES][2];
  logic signed [SW-1:0] sum_r    [cpps_pkg::AXES];
  logic [cpps_pkg::SHIFT_W-1:0] res_nxt [cpps_pkg::AXES];

  cpps_pkg::tag_t tag_s4_r, tag_s5_r, tag_s6_r;
  logic           out_vld_r;
  logic [cpps_pkg::SHIFT_W-1:0] shift_x_r, shift_y_r;

  // signed coefficient times unsigned monomial
  always_comb begin
    logic signed [cpps_pkg::COEF_W-1:0] c;
    logic signed [MW:0]                 m;
    for (int i = 0; i < cpps_pkg::SET_WORDS; i++) begin
      c           = $signed(coef_i[i]);
      m           = $signed({1'b0, mono_i[i % cpps_pkg::TERMS]});
      prod_nxt[i] = PW'(c) * PW'(m);
    end
  end

  always_comb begin
    for (int a = 0; a < cpps_pkg::AXES; a++) begin
      for (int h = 0; h < 2; h++) begin
        half_nxt[a][h] = '0;
        for (int t = 0; t < HALF; t++) begin
          half_nxt[a][h] = half_nxt[a][h] +
                           SW'(prod_r[a*cpps_pkg::TERMS + h*HALF + t]);
        end
      end
    end
  end

  // arithmetic shift floors; then clamp to 32 bits, or zero for a missing set
  always_comb begin
    logic signed [SW-1:0] q;
    logic                 ovf;
    for (int a = 0; a < cpps_pkg::AXES; a++) begin
      q   = sum_r[a] >>> FRAC_BITS;
      ovf = q[QW-1:cpps_pkg::SHIFT_W-1] != {(QW-cpps_pkg::SHIFT_W+1){q[QW-1]}};
      if (!tag_s6_r.ch_ok) begin
        res_nxt[a] = '0;
      end else if (ovf) begin
        res_nxt[a] = q[QW-1] ? {1'b1, {(cpps_pkg::SHIFT_W-1){1'b0}}}
                             : {1'b0, {(cpps_pkg::SHIFT_W-1){1'b1}}};
      end else begin
        res_nxt[a] = q[cpps_pkg::SHIFT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_s4_r  <= '0;
      tag_s5_r  <= '0;
      tag_s6_r  <= '0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      tag_s4_r  <= tag_i;
      tag_s5_r  <= tag_s4_r;
      tag_s6_r  <= tag_s5_r;
      out_vld_r <= tag_s6_r.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r    <= prod_nxt;
      half_r    <= half_nxt;
      for (int a = 0; a < cpps_pkg::AXES; a++) begin
        sum_r[a] <= half_r[a][0] + half_r[a][1];
      end
      shift_x_r <= res_nxt[0];
      shift_y_r <= res_nxt[1];
    end
  end

  assign vld_o     = out_vld_r;
  assign shift_x_o = shift_x_r;
  assign shift_y_o = shift_y_r;

  // a set that does not exist yields a zero shift
  a_bad_ch_zero: assert property (@(posedge clk) disable iff (!rst_n)
    en && tag_s6_r.vld && !tag_s6_r.ch_ok |=>
      out_vld_r && (shift_x_r == '0) && (shift_y_r == '0))
    else $error("nonzero shift for missing coefficient set");

  // a bubble in the last stage never becomes a result
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    en && !tag_s6_r.vld |=> !out_vld_r)
    else $error("result produced from an empty stage");

endmodule

// File: rtl/core/cubic_polynomial_pixel_shift_core.sv
// ----------------------------------------------------------------------------
// cubic_polynomial_pixel_shift_core: per-channel cubic displacement evaluator
// Holds Q16.16 coefficients and evaluates dx, dy at a normalized position.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (in_*): in_tuser selects the item kind. A load item writes
//   one coefficient at coef_index = set*20 + axis*10 + term and gives no
//   result. An evaluate item gives one result on the output stream (out_*)
//   carrying shift_x and shift_y for the chosen set.
//   Loads must reach every coefficient of a set before it is evaluated.
//   Pipeline: an accepted evaluate passes seven register stages (RAM read,
//   two monomial stages, products, two adder stages, output register)
//   before its result is valid.
//   Throughput: one item per clock unless stalled (below); the pipeline's
//   stages advance together, so any mix of loads and evaluates streams without gaps.
//   A load issued right before an evaluate is seen by it, since the write
//   lands at the load's accept edge and the evaluate's RAM read at its own, later accept edge.
//   Stall: while a result waits with out_tready low, the whole pipeline
//   holds and in_tready drops; nothing is lost or repeated.
//   Reset: rst_n clears all valid bits; coefficient contents are undefined
//   until loaded.
// ----------------------------------------------------------------------------
module cubic_polynomial_pixel_shift_core #(
  parameter int COEF_SETS = cpps_pkg::COEF_SETS_DEF,
  parameter int FRAC_BITS = cpps_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input item stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [5:0] coef_index, [37:6] coef_value, [38] channel,
  // [55:39] pos_x, [72:56] pos_y, [79:73] zero
  input  logic [cpps_pkg::IN_DATA_W-1:0]    in_tdata,
  // [0] op
  input  logic                              in_tuser,
  // result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [31:0] shift_x, [63:32] shift_y
  output logic [cpps_pkg::OUT_DATA_W-1:0]   out_tdata
);

  localparam int MW = FRAC_BITS + 1;

  logic                              en;
  logic                              in_acc;
  logic                              op;
  logic [cpps_pkg::IDX_W-1:0]        coef_index;
  logic [cpps_pkg::COEF_W-1:0]       coef_value;
  logic                              channel;
  logic [cpps_pkg::POS_W-1:0]        pos_x;
  logic [cpps_pkg::POS_W-1:0]        pos_y;
  cpps_pkg::tag_t                    tag_in;
  cpps_pkg::tag_t                    tag_mono;
  logic [cpps_pkg::TERMS-1:0][MW-1:0] mono;
  cpps_pkg::coef_set_t               coef;
  logic [cpps_pkg::SHIFT_W-1:0]      shift_x;
  logic [cpps_pkg::SHIFT_W-1:0]      shift_y;

  // unpack the item
  assign op         = in_tuser;
  assign coef_index = in_tdata[5:0];
  assign coef_value = in_tdata[37:6];
  assign channel    = in_tdata[38];
  assign pos_x      = in_tdata[55:39];
  assign pos_y      = in_tdata[72:56];

  // every stage moves together unless a finished result is held
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;
  assign in_acc    = in_tvalid && en;

  // only evaluate items occupy the pipeline
  assign tag_in.vld   = in_acc && (op == cpps_pkg::OP_EVAL);
  assign tag_in.ch_ok = 32'(channel) < 32'(COEF_SETS);

  cpps_coef_store #(
    .COEF_SETS (COEF_SETS)
  ) u_store (
    .clk      (clk),
    .en       (en),
    .wr_en    (in_acc && (op == cpps_pkg::OP_LOAD)),
    .wr_idx   (coef_index),
    .wr_value (coef_value),
    .rd_ch    (channel),
    .coef_o   (coef)
  );

  cpps_mono #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mono (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .tag_i  (tag_in),
    .pos_x  (pos_x),
    .pos_y  (pos_y),
    .tag_o  (tag_mono),
    .mono_o (mono)
  );

  cpps_dot #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dot (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .tag_i     (tag_mono),
    .mono_i    (mono),
    .coef_i    (coef),
    .vld_o     (out_tvalid),
    .shift_x_o (shift_x),
    .shift_y_o (shift_y)
  );

  assign out_tdata = {shift_y, shift_x};

endmodule
